// ===== design/cqd_pkg.sv =====
`default_nettype none
package cqd_pkg;

  // Queue geometry.
  localparam int unsigned QDEPTH = 64;
  localparam int unsigned PTR_W  = $clog2(QDEPTH);
  localparam int unsigned CNT_W  = $clog2(QDEPTH + 1);

  // Depth of the command queue between the front and the back end.
  localparam int unsigned CMDQ_DEPTH = 2;

  // Operation codes of an input item.
  localparam logic [2:0] OP_TICK         = 3'd0;
  localparam logic [2:0] OP_ENQ_MOVE     = 3'd1;
  localparam logic [2:0] OP_ENQ_OPEN     = 3'd2;
  localparam logic [2:0] OP_ENQ_DELAY    = 3'd3;
  localparam logic [2:0] OP_ENQ_OPEN_DEF = 3'd4;

  // Command codes, as issued and as stored in the code byte.
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_MOVE  = 2'd1;
  localparam logic [1:0] CMD_OPEN  = 2'd2;
  localparam logic [1:0] CMD_DELAY = 2'd3;

  // Byte counts of the stored commands.
  localparam logic [2:0] LEN_MOVE  = 3'd5;
  localparam logic [2:0] LEN_OPEN  = 3'd4;
  localparam logic [2:0] LEN_DELAY = 3'd3;

  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_TICK,
    KIND_ENQ
  } cqd_kind_e;

  typedef struct packed {
    logic [2:0]        op;
    logic signed [31:0] position;
    logic [7:0]        valve_index;
    logic [15:0]       duration;
    logic              motor_busy;
    logic              valve_busy;
    logic              delay_busy;
  } cqd_in_t;

  typedef struct packed {
    logic              accepted;
    logic [1:0]        issued;
    logic signed [31:0] issue_position;
    logic [7:0]        issue_valve;
    logic [15:0]       issue_duration;
    logic [1:0]        active_command;
  } cqd_out_t;

  // A classified item: for an enqueue the bytes to store, first byte on top.
  typedef struct packed {
    cqd_kind_e   kind;
    logic [2:0]  nbytes;
    logic [39:0] bytes;
    logic        motor_busy;
    logic        valve_busy;
    logic        delay_busy;
  } cqd_cmd_t;

endpackage
`default_nettype wire

// ===== design/command_queue_dispatcher_top.sv =====
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_stall_o  in_data_i  (cqd_in_t)
// out      output     out_valid_o / out_stall_i out_data_o (cqd_out_t)
// cfg      input      cfg_we_i                 cfg_data_i (default open time)
//
// Every input transfer yields exactly one output transfer, in order.
// An enqueue writes its bytes one at a time through ST_WRITE (none when it
// is dropped); a dispatching tick reads the code byte and then each command
// byte through ST_RCODE and ST_RDATA, and any other tick goes straight to
// ST_FIN. The queue memory has a single byte-wide port. A two-entry command
// queue sits between the front and the back end.
// Reset is asynchronous and active low; the queue storage is not cleared.
// A stalled output is held in the result register while the next item runs.
`default_nettype none
module command_queue_dispatcher_top import cqd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire cqd_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output cqd_out_t         out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_data_i
);

  // Classified items flow from the front end through the command queue.
  logic     cmd_push;
  logic     cmdq_full;
  cqd_cmd_t front_cmd;
  logic     cmdq_valid;
  logic     cmdq_pop;
  cqd_cmd_t back_cmd;

  // The front end decodes each transfer, resolves the default open time and
  // lays out the bytes to store.
  cqd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (cmdq_full),
    .push_o     (cmd_push),
    .cmd_o      (front_cmd)
  );

  cqd_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (front_cmd),
    .full_o  (cmdq_full),
    .pop_i   (cmdq_pop),
    .valid_o (cmdq_valid),
    .cmd_o   (back_cmd)
  );

  // The back end owns the byte queue, the active command and the result
  // register.
  cqd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmdq_valid),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (cmdq_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTH
  // An enqueue result never issues a command.
  a_acc_no_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.accepted |-> out_data_o.issued == CMD_NONE)
    else $error("enqueue result carries an issued command");

  // An issued command is the active one after the step.
  a_issue_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.issued != CMD_NONE
    |-> out_data_o.active_command == out_data_o.issued)
    else $error("issued command is not active");

  // Fields that do not belong to the issued command read as zero; this checks the position.
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.issued != CMD_MOVE |-> out_data_o.issue_position == 0)
    else $error("position set for a command other than move");
`endif

endmodule
`default_nettype wire

// ===== design/cqd_front.sv =====
`default_nettype none
module cqd_front import cqd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire cqd_in_t  in_data_i,
  output logic          in_stall_o,
  input  wire logic     cfg_we_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic     q_full_i,
  output logic          push_o,
  output cqd_cmd_t      cmd_o
);

  logic [15:0] open_time_q, open_time_d;

  always_comb begin
    open_time_d = cfg_we_i ? cfg_data_i : open_time_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_time_q <= '0;
    end else begin
      open_time_q <= open_time_d;
    end
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Classify the item and lay out its bytes in storage order.
  always_comb begin
    cmd_o            = '0;
    cmd_o.motor_busy = in_data_i.motor_busy;
    cmd_o.valve_busy = in_data_i.valve_busy;
    cmd_o.delay_busy = in_data_i.delay_busy;
    unique case (in_data_i.op)
      OP_TICK: begin
        cmd_o.kind = KIND_TICK;
      end
      OP_ENQ_MOVE: begin
        cmd_o.kind   = KIND_ENQ;
        cmd_o.nbytes = LEN_MOVE;
        cmd_o.bytes  = {6'd0, CMD_MOVE, in_data_i.position};
      end
      OP_ENQ_OPEN: begin
        cmd_o.kind   = KIND_ENQ;
        cmd_o.nbytes = LEN_OPEN;
        cmd_o.bytes  = {6'd0, CMD_OPEN, in_data_i.valve_index, in_data_i.duration, 8'd0};
      end
      OP_ENQ_OPEN_DEF: begin
        cmd_o.kind   = KIND_ENQ;
        cmd_o.nbytes = LEN_OPEN;
        cmd_o.bytes  = {6'd0, CMD_OPEN, in_data_i.valve_index, open_time_q, 8'd0};
      end
      OP_ENQ_DELAY: begin
        cmd_o.kind   = KIND_ENQ;
        cmd_o.nbytes = LEN_DELAY;
        cmd_o.bytes  = {6'd0, CMD_DELAY, in_data_i.duration, 16'd0};
      end
      default: begin
        cmd_o.kind = KIND_NOP;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/cqd_cmdq.sv =====
`default_nettype none
module cqd_cmdq import cqd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire cqd_cmd_t cmd_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          valid_o,
  output cqd_cmd_t      cmd_o
);

  localparam int unsigned QP_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int unsigned QC_W = $clog2(CMDQ_DEPTH + 1);

  cqd_cmd_t         entry_q [CMDQ_DEPTH];
  logic [QP_W-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [QC_W-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  function automatic logic [QP_W-1:0] qp_next(input logic [QP_W-1:0] p);
    qp_next = (p == QP_W'(CMDQ_DEPTH - 1)) ? '0 : p + QP_W'(1);
  endfunction

  assign full_o  = (cnt_q == QC_W'(CMDQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = entry_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wp_d  = do_push ? qp_next(wp_q) : wp_q;
    rp_d  = do_pop ? qp_next(rp_q) : rp_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QC_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wp_q] <= cmd_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/cqd_back.sv =====
`default_nettype none
module cqd_back import cqd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cmd_valid_i,
  input  wire cqd_cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output cqd_out_t      out_data_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WRITE = 3'd1;
  localparam logic [2:0] ST_RCODE = 3'd2;
  localparam logic [2:0] ST_RDATA = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]       st_q, st_d;
  logic [PTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [1:0]       cur_q, cur_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [39:0]      sh_q, sh_d;
  logic [31:0]      acc_q, acc_d;
  logic             accf_q, accf_d;
  logic [1:0]       iss_q, iss_d;
  logic             out_valid_q, out_valid_d;
  cqd_out_t         out_q, out_d;

  logic [7:0]       queue_mem_q [QDEPTH];
  logic [7:0]       mem_rd_q;
  logic             mem_we, mem_re;

  logic [CNT_W:0]   room_sum;
  logic             room;
  logic             busy_cur;
  logic             slot_free;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign room_sum  = (CNT_W+1)'(fill_q) + (CNT_W+1)'(cmd_i.nbytes);
  assign room      = room_sum < (CNT_W+1)'(QDEPTH);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign cmd_pop_o = (st_q == ST_IDLE) && cmd_valid_i;

  always_comb begin
    unique case (cur_q)
      CMD_MOVE:  busy_cur = cmd_i.motor_busy;
      CMD_OPEN:  busy_cur = cmd_i.valve_busy;
      CMD_DELAY: busy_cur = cmd_i.delay_busy;
      default:   busy_cur = 1'b0;
    endcase
  end

  always_comb begin
    st_d        = st_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    fill_d      = fill_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    sh_d        = sh_q;
    acc_d       = acc_q;
    accf_d      = accf_q;
    iss_d       = iss_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    unique case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          accf_d = 1'b0;
          iss_d  = CMD_NONE;
          acc_d  = '0;
          st_d   = ST_FIN;
          unique case (cmd_i.kind)
            KIND_ENQ: begin
              if (room) begin
                accf_d = 1'b1;
                sh_d   = cmd_i.bytes;
                cnt_d  = cmd_i.nbytes;
                st_d   = ST_WRITE;
              end
            end
            KIND_TICK: begin
              if (cur_q != CMD_NONE) begin
                if (!busy_cur) begin
                  cur_d = CMD_NONE;
                end
              end else if (fill_q != '0) begin
                mem_re = 1'b1;
                rp_d   = ptr_next(rp_q);
                fill_d = fill_q - CNT_W'(1);
                st_d   = ST_RCODE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_WRITE: begin
        mem_we = 1'b1;
        sh_d   = {sh_q[31:0], 8'd0};
        wp_d   = ptr_next(wp_q);
        fill_d = fill_q + CNT_W'(1);
        cnt_d  = cnt_q - 3'd1;
        if (cnt_q == 3'd1) begin
          st_d = ST_FIN;
        end
      end
      ST_RCODE: begin
        // Only the three defined codes start a command.
        if (mem_rd_q[7:2] == 6'd0 && mem_rd_q[1:0] != CMD_NONE) begin
          iss_d = mem_rd_q[1:0];
        end else begin
          iss_d = CMD_NONE;
        end
        cur_d = iss_d;
        unique case (iss_d)
          CMD_MOVE:  cnt_d = LEN_MOVE - 3'd1;
          CMD_OPEN:  cnt_d = LEN_OPEN - 3'd1;
          CMD_DELAY: cnt_d = LEN_DELAY - 3'd1;
          default:   cnt_d = 3'd0;
        endcase
        if (cnt_d == 3'd0) begin
          st_d = ST_FIN;
        end else begin
          mem_re = 1'b1;
          rp_d   = ptr_next(rp_q);
          fill_d = fill_q - CNT_W'(1);
          st_d   = ST_RDATA;
        end
      end
      ST_RDATA: begin
        acc_d = {acc_q[23:0], mem_rd_q};
        cnt_d = cnt_q - 3'd1;
        if (cnt_q == 3'd1) begin
          st_d = ST_FIN;
        end else begin
          mem_re = 1'b1;
          rp_d   = ptr_next(rp_q);
          fill_d = fill_q - CNT_W'(1);
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          out_valid_d          = 1'b1;
          out_d.accepted       = accf_q;
          out_d.issued         = iss_q;
          out_d.issue_position = (iss_q == CMD_MOVE) ? acc_q : '0;
          out_d.issue_valve    = (iss_q == CMD_OPEN) ? acc_q[23:16] : '0;
          out_d.issue_duration = (iss_q == CMD_OPEN || iss_q == CMD_DELAY) ?
                                 acc_q[15:0] : '0;
          out_d.active_command = cur_q;
          st_d                 = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      fill_q      <= '0;
      cur_q       <= CMD_NONE;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      fill_q      <= fill_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    sh_q   <= sh_d;
    acc_q  <= acc_d;
    accf_q <= accf_d;
    iss_q  <= iss_d;
    out_q  <= out_d;
  end

  // Byte-wide queue storage: one write or one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      queue_mem_q[wp_q] <= sh_q[39:32];
    end
    if (mem_re) begin
      mem_rd_q <= queue_mem_q[rp_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire
